@@ hdl/assert_macros.svh @@
// Assertion macros shared by the controller port RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

@@ hdl/jpt_pkg.sv @@
// Shared types, constants and duty-pattern functions for the controller port.
`timescale 1ns / 1ps
`default_nettype none

package jpt_pkg;

	localparam int NUM_PADS = 4;
	localparam int RAW_W = 10;
	localparam int PAD_W = 8;
	localparam int MAIN_W = 20;
	localparam int AUX_W = 8;
	localparam int CNT_W = 3;

	localparam logic [1:0] CMD_FRAME = 2'd0;
	localparam logic [1:0] CMD_WRITE = 2'd1;
	localparam logic [1:0] CMD_READ = 2'd2;

	localparam logic [15:0] PORT_FIRST = 16'h4016;
	localparam logic [15:0] PORT_SECOND = 16'h4017;

	localparam logic [MAIN_W-1:0] SIG_FIRST = 20'h80000;
	localparam logic [MAIN_W-1:0] SIG_SECOND = 20'h40000;

	localparam logic REG_FOUR_PLAYER = 1'b0;
	localparam logic REG_TURBO_SPEEDS = 1'b1;

	typedef struct packed {
		logic [1:0] cmd;
		logic [15:0] addr;
		logic [7:0] write_data;
		logic [NUM_PADS*RAW_W-1:0] buttons;
	} item_t;

	// Control handed from the input stage to the port logic.
	typedef struct packed {
		logic step;
		logic [1:0] cmd;
		logic [15:0] addr;
		logic strobe;
		logic mic;
	} bus_t;

	function automatic logic [CNT_W-1:0] duty_period(input logic [1:0] spd);
		logic [CNT_W-1:0] p;
		case (spd)
			2'd0: p = 3'd6;
			2'd1: p = 3'd4;
			2'd2: p = 3'd3;
			default: p = 3'd2;
		endcase
		return p;
	endfunction

	// Half of each period drives the button on, rounded up, at least one step.
	function automatic logic duty_on(input logic [1:0] spd, input logic [CNT_W-1:0] cnt);
		logic on;
		case (spd)
			2'd0: on = (cnt < 3'd3);
			2'd1: on = (cnt < 3'd2);
			2'd2: on = (cnt < 3'd2);
			default: on = (cnt < 3'd1);
		endcase
		return on;
	endfunction

endpackage

`default_nettype wire

@@ hdl/jpt_in_if.sv @@
// Input channel: one command beat with bus fields and button levels.
`timescale 1ns / 1ps
`default_nettype none

interface jpt_in_if;
	logic valid;
	logic ready;
	logic [1:0] cmd;
	logic [15:0] addr;
	logic [7:0] write_data;
	logic [39:0] buttons;

	modport source (output valid, output cmd, output addr, output write_data,
		output buttons, input ready);
	modport sink (input valid, input cmd, input addr, input write_data,
		input buttons, output ready);
endinterface

`default_nettype wire

@@ hdl/jpt_out_if.sv @@
// Output channel: one read-data beat per command.
`timescale 1ns / 1ps
`default_nettype none

interface jpt_out_if;
	logic valid;
	logic ready;
	logic [2:0] read_data;

	modport source (output valid, output read_data, input ready);
	modport sink (input valid, input read_data, output ready);
endinterface

`default_nettype wire

@@ hdl/jpt_pad.sv @@
// One pad: direction cancelling, turbo duty counters and the stored pad byte.
`timescale 1ns / 1ps
`default_nettype none

module jpt_pad (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic frame,
	input wire logic [jpt_pkg::RAW_W-1:0] raw,
	input wire logic [3:0] speeds,
	input wire logic keep_startsel,
	output logic [jpt_pkg::PAD_W-1:0] pad_byte
);

	logic [1:0][jpt_pkg::CNT_W-1:0] cnt_q;
	logic [1:0][jpt_pkg::CNT_W-1:0] cnt_d;
	logic [1:0] btn;
	logic [3:0] dir;
	logic [jpt_pkg::PAD_W-1:0] pad_q;
	logic [jpt_pkg::PAD_W-1:0] pad_d;

	always_comb begin
		logic [1:0] spd;
		logic [jpt_pkg::CNT_W-1:0] cnt_eff;
		dir = raw[3:0];
		if (dir[1:0] == 2'b11) begin
			dir[1:0] = 2'b00;
		end
		if (dir[3:2] == 2'b11) begin
			dir[3:2] = 2'b00;
		end
		for (int b = 0; b < 2; b++) begin
			spd = speeds[2*b +: 2];
			cnt_eff = (cnt_q[b] >= jpt_pkg::duty_period(spd)) ? '0 : cnt_q[b];
			if (raw[6+b]) begin
				btn[b] = jpt_pkg::duty_on(spd, cnt_eff);
				cnt_d[b] = cnt_eff + 3'd1;
			end else begin
				btn[b] = raw[4+b];
				cnt_d[b] = '0;
			end
		end
		pad_d = {dir, keep_startsel ? raw[9:8] : 2'b00, btn};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			pad_q <= '0;
		end else if (frame) begin
			cnt_q <= cnt_d;
			pad_q <= pad_d;
		end
	end

	assign pad_byte = pad_q;

endmodule

`default_nettype wire

@@ hdl/jpt_ports.sv @@
// Strobe, shift registers and mic level of the two bus ports.
`timescale 1ns / 1ps
`default_nettype none

module jpt_ports (
	input wire logic clk,
	input wire logic arst_n,
	input wire jpt_pkg::bus_t bus,
	input wire logic four_player,
	input wire logic [jpt_pkg::NUM_PADS-1:0][jpt_pkg::PAD_W-1:0] pad_bytes,
	output logic [2:0] read_data
);

	logic strobe_armed_q;
	logic mic_level_q;
	logic [jpt_pkg::MAIN_W-1:0] main_first_q;
	logic [jpt_pkg::MAIN_W-1:0] main_second_q;
	logic [jpt_pkg::AUX_W-1:0] aux_first_q;
	logic [jpt_pkg::AUX_W-1:0] aux_second_q;
	logic [jpt_pkg::MAIN_W-1:0] load_first;
	logic [jpt_pkg::MAIN_W-1:0] load_second;

	always_comb begin
		if (four_player) begin
			load_first = jpt_pkg::SIG_FIRST | {4'b0000, pad_bytes[2], pad_bytes[0]};
			load_second = jpt_pkg::SIG_SECOND | {4'b0000, pad_bytes[3], pad_bytes[1]};
		end else begin
			load_first = {12'h000, pad_bytes[0]};
			load_second = {12'h000, pad_bytes[1]};
		end
	end

	always_comb begin
		read_data = 3'b000;
		if (bus.cmd == jpt_pkg::CMD_READ) begin
			if (bus.addr == jpt_pkg::PORT_FIRST) begin
				read_data = {mic_level_q, aux_first_q[0], main_first_q[0]};
			end else if (bus.addr == jpt_pkg::PORT_SECOND) begin
				read_data = {1'b0, aux_second_q[0], main_second_q[0]};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_armed_q <= 1'b0;
			mic_level_q <= 1'b0;
			main_first_q <= '0;
			main_second_q <= '0;
			aux_first_q <= '0;
			aux_second_q <= '0;
		end else if (bus.step) begin
			case (bus.cmd)
				jpt_pkg::CMD_FRAME: begin
					mic_level_q <= bus.mic;
				end
				jpt_pkg::CMD_WRITE: begin
					// The shift registers load on the falling edge of an armed strobe.
					if (bus.addr == jpt_pkg::PORT_FIRST) begin
						if (bus.strobe) begin
							strobe_armed_q <= 1'b1;
						end else if (strobe_armed_q) begin
							strobe_armed_q <= 1'b0;
							main_first_q <= load_first;
							main_second_q <= load_second;
							aux_first_q <= pad_bytes[2];
							aux_second_q <= pad_bytes[3];
						end
					end
				end
				jpt_pkg::CMD_READ: begin
					if (bus.addr == jpt_pkg::PORT_FIRST) begin
						main_first_q <= main_first_q >> 1;
						aux_first_q <= aux_first_q >> 1;
					end else if (bus.addr == jpt_pkg::PORT_SECOND) begin
						main_second_q <= main_second_q >> 1;
						aux_second_q <= aux_second_q >> 1;
					end
				end
				default: begin
				end
			endcase
		end
	end

endmodule

`default_nettype wire

@@ hdl/joypad_port_with_turbo_top.sv @@
// A beat accepted into the input stage gives its result beat from the result register.
// Throughput: one command beat per cycle, sustained while the result side takes beats.
// The input stage and the result register part the two channels, so a waiting
// result still lets the next command be taken while the input stage is empty.
// Reset (arst_n low) clears configuration, pad bytes, turbo counters, strobe,
// mic level and shift registers at once.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module joypad_port_with_turbo_top (
	input wire logic clk,
	input wire logic arst_n,
	jpt_in_if.sink items,
	jpt_out_if.source results,
	input wire logic wr_en,
	input wire logic wr_index,
	input wire logic [15:0] wr_data
);

	logic four_player_q;
	logic [15:0] turbo_speeds_q;
	logic s1_valid_q;
	jpt_pkg::item_t s1_q;
	logic out_valid_q;
	logic [2:0] read_data_q;
	logic advance;
	logic frame;
	logic [2:0] read_data;
	jpt_pkg::bus_t bus;
	logic [jpt_pkg::NUM_PADS-1:0][jpt_pkg::PAD_W-1:0] pad_bytes;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			four_player_q <= 1'b0;
			turbo_speeds_q <= '0;
		end else if (wr_en) begin
			case (wr_index)
				jpt_pkg::REG_FOUR_PLAYER: four_player_q <= wr_data[0];
				jpt_pkg::REG_TURBO_SPEEDS: turbo_speeds_q <= wr_data;
				default: begin
				end
			endcase
		end
	end

	assign advance = s1_valid_q && (!out_valid_q || results.ready);
	assign items.ready = !s1_valid_q || advance;
	assign frame = advance && (s1_q.cmd == jpt_pkg::CMD_FRAME);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (items.valid && items.ready) begin
			s1_valid_q <= 1'b1;
		end else if (advance) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (items.valid && items.ready) begin
			s1_q <= '{cmd: items.cmd, addr: items.addr, write_data: items.write_data,
				buttons: items.buttons};
		end
	end

	genvar g;
	generate
		for (g = 0; g < jpt_pkg::NUM_PADS; g++) begin : g_pad
			jpt_pad u_pad (
				.clk(clk),
				.arst_n(arst_n),
				.frame(frame),
				.raw(s1_q.buttons[jpt_pkg::RAW_W*g +: jpt_pkg::RAW_W]),
				.speeds(turbo_speeds_q[4*g +: 4]),
				.keep_startsel(1'(g == 0)),
				.pad_byte(pad_bytes[g])
			);
		end
	endgenerate

	// Pad 1's raw start and select drive the mic level.
	assign bus = '{step: advance, cmd: s1_q.cmd, addr: s1_q.addr,
		strobe: s1_q.write_data[0],
		mic: |s1_q.buttons[jpt_pkg::RAW_W+9 : jpt_pkg::RAW_W+8]};

	jpt_ports u_ports (
		.clk(clk),
		.arst_n(arst_n),
		.bus(bus),
		.four_player(four_player_q),
		.pad_bytes(pad_bytes),
		.read_data(read_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			read_data_q <= read_data;
		end
	end

	assign results.valid = out_valid_q;
	assign results.read_data = read_data_q;

	`ASSERT_NEXT(a_advance_fills_result, clk, arst_n, advance, out_valid_q)
	`ASSERT_NEXT(a_only_reads_give_data, clk, arst_n, advance && (s1_q.cmd != jpt_pkg::CMD_READ), read_data_q == 3'b000)
	`ASSERT_IMPLIES(a_stall_needs_held_item, clk, arst_n, !items.ready, s1_valid_q && out_valid_q)

endmodule

`default_nettype wire
